[rtl/rjctr_pkg.sv]
// Shared types, constants and AES round functions for the Rijndael-256 counter-mode block.
package rjctr_pkg;

	localparam int MAX_ROUNDS = 38;
	localparam int KEY_ROWS   = MAX_ROUNDS + 1;
	localparam int KEY_WORDS  = 4 * KEY_ROWS;
	localparam int ROW_W      = $clog2(KEY_ROWS);
	localparam int QUEUE_DEPTH = 4;
	localparam logic [5:0] ROUNDS_RESET = 6'd22;

	localparam logic [1:0] REQ_KEY  = 2'd0;
	localparam logic [1:0] REQ_CTR  = 2'd1;
	localparam logic [1:0] REQ_DATA = 2'd2;

	typedef enum logic [1:0] {
		KIND_KEY,
		KIND_CTR,
		KIND_DATA
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  idx;
		logic [63:0] data;
		logic [3:0]  vb;
		logic        last;
	} item_t;

	// Byte i of the blend takes the other half where bit i is set.
	localparam logic [15:0] BLEND_SEL = 16'h8CCE;
	localparam int SHUFFLE_IDX [16] = '{0, 1, 6, 7, 4, 5, 10, 11, 8, 9, 14, 15, 12, 13, 2, 3};

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	// ShiftRows, SubBytes, optional MixColumns, AddRoundKey; byte i sits in bits 8i+7..8i.
	function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] k,
			input logic last);
		logic [7:0]   t [16];
		logic [7:0]   a0, a1, a2, a3;
		logic [127:0] o;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[r + 4 * c] = SBOX[s[8 * (r + 4 * ((c + r) % 4)) +: 8]];
			end
		end
		if (!last) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[4 * c];
				a1 = t[4 * c + 1];
				a2 = t[4 * c + 2];
				a3 = t[4 * c + 3];
				t[4 * c]     = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
				t[4 * c + 1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
				t[4 * c + 2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
				t[4 * c + 3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
			end
		end
		for (int i = 0; i < 16; i++) begin
			o[8 * i +: 8] = t[i] ^ k[8 * i +: 8];
		end
		return o;
	endfunction

	// One cipher round over both halves; result is {half2, half1}.
	function automatic logic [255:0] round_pair(input logic [127:0] h1, input logic [127:0] h2,
			input logic [127:0] k1, input logic [127:0] k2, input logic last);
		logic [127:0] t1, t2, u1, u2;
		for (int i = 0; i < 16; i++) begin
			t1[8 * i +: 8] = BLEND_SEL[i] ? h2[8 * i +: 8] : h1[8 * i +: 8];
			t2[8 * i +: 8] = BLEND_SEL[i] ? h1[8 * i +: 8] : h2[8 * i +: 8];
		end
		for (int i = 0; i < 16; i++) begin
			u1[8 * i +: 8] = t1[8 * SHUFFLE_IDX[i] +: 8];
			u2[8 * i +: 8] = t2[8 * SHUFFLE_IDX[i] +: 8];
		end
		return {aes_round(u2, k2, last), aes_round(u1, k1, last)};
	endfunction

endpackage

[rtl/rjctr_front.sv]
// Front end: accepts input beats, drops ones with no effect, and classifies the rest.
module rjctr_front import rjctr_pkg::*; (
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [7:0]  word_index,
	input  logic [63:0] data_in,
	input  logic [3:0]  valid_bytes,
	input  logic        last_word,
	input  logic        q_full,
	output logic        q_push,
	output item_t       q_item
);

	logic keep;

	always_comb begin
		keep = 1'b0;
		q_item.kind = KIND_DATA;
		unique case (req_type)
			REQ_KEY: begin
				q_item.kind = KIND_KEY;
				keep = ({24'd0, word_index} < KEY_WORDS);
			end
			REQ_CTR: begin
				q_item.kind = KIND_CTR;
				keep = 1'b1;
			end
			REQ_DATA: begin
				q_item.kind = KIND_DATA;
				keep = 1'b1;
			end
			default: keep = 1'b0;
		endcase
		q_item.idx  = word_index;
		q_item.data = data_in;
		if (valid_bytes == 4'd0) begin
			q_item.vb = 4'd1;
		end else if (valid_bytes > 4'd8) begin
			q_item.vb = 4'd8;
		end else begin
			q_item.vb = valid_bytes;
		end
		q_item.last = last_word;
	end

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full && keep;

endmodule

[rtl/rjctr_queue.sv]
// Short queue of classified items between the front end and the cipher engine.
module rjctr_queue import rjctr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output item_t head,
	output logic  full,
	output logic  empty
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	item_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full  = (count_q == (PTR_W + 1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/rjctr_back.sv]
// Cipher engine: round-key memory, counter, keystream buffer and the output register.
module rjctr_back import rjctr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [5:0]  cfg_wdata,
	input  item_t       head,
	input  logic        q_empty,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] data_out,
	output logic [3:0]  out_valid_bytes,
	output logic        out_last
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WHITEN,
		ST_ROUND,
		ST_EMIT
	} state_t;

	state_t           state_q;
	logic [5:0]       rounds_q;
	logic [5:0]       rounds;
	logic [5:0]       rnd_q;
	logic [ROW_W-1:0] rd_row;
	logic [63:0]      bank_q [4][KEY_ROWS];
	logic [63:0]      rdata_q [4];
	logic [63:0]      ctr_q [4];
	logic [63:0]      ks_q [4];
	logic [255:0]     h_q;
	logic [255:0]     h_next;
	logic [1:0]       wp_q;
	logic             out_free;
	logic             head_data, head_key, head_ctr;
	logic             emit;
	logic             last_round;
	logic [63:0]      mask;
	logic [127:0]     ctr_inc;

	always_comb begin
		if (rounds_q < 6'd2) begin
			rounds = 6'd2;
		end else if (rounds_q > 6'(MAX_ROUNDS)) begin
			rounds = 6'(MAX_ROUNDS);
		end else begin
			rounds = rounds_q;
		end
	end

	assign head_data = !q_empty && (head.kind == KIND_DATA);
	assign head_key  = !q_empty && (head.kind == KIND_KEY);
	assign head_ctr  = !q_empty && (head.kind == KIND_CTR);
	assign out_free  = !out_valid || !out_stall;
	assign emit = out_free && ((state_q == ST_EMIT) ||
		(state_q == ST_IDLE && head_data && wp_q != 2'd0));
	assign q_pop = emit || (state_q == ST_IDLE && (head_key || head_ctr));

	// The key row for the next step is read ahead into the rdata_q register.
	assign rd_row = (state_q == ST_IDLE) ? '0 : ROW_W'(rnd_q + 6'd1);
	assign last_round = (rnd_q == rounds);
	assign h_next = round_pair(h_q[127:0], h_q[255:128], {rdata_q[1], rdata_q[0]},
		{rdata_q[3], rdata_q[2]}, last_round);
	assign ctr_inc = {ctr_q[1], ctr_q[0]} + 128'd1;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			mask[8 * i +: 8] = (4'(i) < head.vb) ? 8'hff : 8'h00;
		end
	end

	always_ff @(posedge clk) begin
		for (int b = 0; b < 4; b++) begin
			if (state_q == ST_IDLE && head_key && head.idx[1:0] == 2'(b)) begin
				bank_q[b][head.idx[7:2]] <= head.data;
			end
			if ({26'd0, rd_row} < KEY_ROWS) begin
				rdata_q[b] <= bank_q[b][rd_row];
			end
		end
		if (emit) begin
			data_out        <= (head.data ^ ks_q[wp_q]) & mask;
			out_valid_bytes <= head.vb;
			out_last        <= head.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rounds_q  <= ROUNDS_RESET;
			rnd_q     <= '0;
			wp_q      <= '0;
			out_valid <= 1'b0;
			h_q       <= '0;
			for (int i = 0; i < 4; i++) begin
				ctr_q[i] <= '0;
				ks_q[i]  <= '0;
			end
		end else begin
			if (cfg_we) begin
				rounds_q <= cfg_wdata;
			end
			if (emit) begin
				out_valid <= 1'b1;
				wp_q <= head.last ? 2'd0 : wp_q + 2'd1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (head_ctr) begin
						ctr_q[head.idx[1:0]] <= head.data;
						wp_q <= '0;
					end else if (head_data && wp_q == 2'd0) begin
						rnd_q   <= '0;
						state_q <= ST_WHITEN;
					end
				end
				ST_WHITEN: begin
					h_q <= {ctr_q[3] ^ rdata_q[3], ctr_q[2] ^ rdata_q[2],
						ctr_q[1] ^ rdata_q[1], ctr_q[0] ^ rdata_q[0]};
					rnd_q   <= 6'd1;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					h_q   <= h_next;
					rnd_q <= rnd_q + 6'd1;
					if (last_round) begin
						for (int i = 0; i < 4; i++) begin
							ks_q[i] <= h_next[64 * i +: 64];
						end
						ctr_q[0] <= ctr_inc[63:0];
						ctr_q[1] <= ctr_inc[127:64];
						state_q  <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_wp_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!emit && !(state_q == ST_IDLE && head_ctr) |=> $stable(wp_q))
		else $error("keystream position moved without a result or counter load");

	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND |-> (rnd_q >= 6'd1 && rnd_q <= rounds))
		else $error("round count outside the configured range");

	a_pop_state: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (state_q == ST_IDLE || state_q == ST_EMIT))
		else $error("queue popped while a block is being computed");

	a_fresh_block: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND && last_round |=> state_q == ST_EMIT && wp_q == 2'd0)
		else $error("finished block not used at keystream word zero");

endmodule

[rtl/rijndael256_ctr_keystream_xor_top.sv]
// Top level of the Rijndael-256 counter-mode keystream XOR block.
// Key-word and counter-word beats are handled in the idle state, as is a data beat that
// uses an already computed keystream word. A data beat that starts a new 256-bit
// keystream block goes through key row 0 read, whitening, one round pair per cycle and
// the result; the default is 22 rounds.
// A single AES round-pair unit is fed by the four-bank round-key memory.
// A four-entry queue lets input beats be taken while the engine is busy.
module rijndael256_ctr_keystream_xor_top import rjctr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [5:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [7:0]  word_index,
	input  logic [63:0] data_in,
	input  logic [3:0]  valid_bytes,
	input  logic        last_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] data_out,
	output logic [3:0]  out_valid_bytes,
	output logic        out_last
);

	item_t push_item, head;
	logic  push, pop, q_full, q_empty;

	rjctr_front u_front (
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.word_index  (word_index),
		.data_in     (data_in),
		.valid_bytes (valid_bytes),
		.last_word   (last_word),
		.q_full      (q_full),
		.q_push      (push),
		.q_item      (push_item)
	);

	rjctr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	rjctr_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.head            (head),
		.q_empty         (q_empty),
		.q_pop           (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.data_out        (data_out),
		.out_valid_bytes (out_valid_bytes),
		.out_last        (out_last)
	);

endmodule
